@@ hdl/goal_frame_decoder_with_bearing_assert.svh @@
// Assertion macros for the goal frame decoder.
// Needs a clock named clk and an active-high reset named rst in the including module.
`ifndef GOAL_FRAME_DECODER_WITH_BEARING_ASSERT_SVH
`define GOAL_FRAME_DECODER_WITH_BEARING_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GFD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("goal frame decoder: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define GFD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("goal frame decoder: assertion failed");

`endif

@@ hdl/gfd_pkg.sv @@
// Types and constants for the goal frame decoder.
// No dependencies; imported by goal_frame_decoder_with_bearing and its testbench.
package gfd_pkg;

  localparam logic [7:0] HEADER_BYTE = 8'h41;
  localparam logic signed [8:0] NOT_LOCATED = -9'sd181;
  localparam logic signed [8:0] DEG_MAX = 9'sd180;
  localparam logic signed [8:0] DEG_MIN = -9'sd180;
  localparam logic signed [8:0] DEG_RIGHT = 9'sd90;
  localparam logic signed [8:0] DEG_LEFT = -9'sd90;

  // Configuration register indexes.
  localparam logic [1:0] REG_VIS_MODE = 2'd0;
  localparam logic [1:0] REG_OWN_THR = 2'd1;
  localparam logic [1:0] REG_OPS_THR = 2'd2;

  // Arctangent table: atan(2^-i) in units of 2^-16 degree.
  localparam int TBL_N = 16;
  localparam int TBL_W = 4;
  localparam int ATAN_W = 22;
  localparam logic [ATAN_W-1:0] ATAN_TABLE [TBL_N] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
    22'd234379, 22'd117304, 22'd58666, 22'd29335,
    22'd14668, 22'd7334, 22'd3667, 22'd1833,
    22'd917, 22'd458, 22'd229, 22'd115
  };

  // Vector components carry 16 fraction bits; the angle accumulator too.
  localparam int FRAC_W = 16;
  localparam int VEC_W = 27;
  localparam int ANG_W = 26;
  localparam logic signed [ANG_W-1:0] BASE_POS = 26'sd11796480;
  localparam logic signed [ANG_W-1:0] BASE_NEG = -26'sd11796480;

  localparam int OUT_W = 88;

  typedef enum logic [4:0] {
    ST_RECV = 5'b00001,
    ST_PREP = 5'b00010,
    ST_ITER = 5'b00100,
    ST_FIN  = 5'b01000,
    ST_LOAD = 5'b10000
  } state_t;

endpackage

@@ hdl/goal_frame_decoder_with_bearing.sv @@
// Goal frame decoder: after the last frame byte, one shared CORDIC unit finds the
// bearing of the own goal, then of the opposing goal, one step per cycle, and no
// byte is taken meanwhile. Bytes are taken one per cycle while receiving; a frame
// is 7 bytes. A finished result waits in the output register while new bytes
// are taken. Synchronous reset clears the frame position, the sequencer, the
// output valid flag and the configuration registers.
module goal_frame_decoder_with_bearing
  import gfd_pkg::*;
#(
  parameter int ANGLE_ITERATIONS = 12
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,  // rx_byte
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // own_x, own_y, ops_x, ops_y, own_left_end, own_right_end, ops_left_end,
  // ops_right_end, own_bearing, ops_bearing, own_seen, ops_seen
  output logic [OUT_W-1:0]  m_axis_tdata,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_wdata
);

  localparam int NITER = (ANGLE_ITERATIONS > TBL_N) ? TBL_N : ANGLE_ITERATIONS;
  localparam int ITER_W = $clog2(NITER + 1);

  state_t state;
  logic [2:0] pos;
  logic [7:0] fields [6];
  logic goal_sel;
  logic [ITER_W-1:0] iter;
  logic signed [VEC_W-1:0] re, im;
  logic signed [ANG_W-1:0] z;
  logic signed [8:0] own_brg, ops_brg;
  logic vis_mode;
  logic [7:0] own_thr, ops_thr;
  logic out_valid;
  logic [OUT_W-1:0] out_data;

  logic in_acc;
  logic load_go;
  logic [7:0] gx, gy;
  logic gx_m1, gy_m1;
  logic signed [VEC_W-1:0] re0, im0, re_sh, im_sh;
  logic [ATAN_W-1:0] atan_i;
  logic signed [ANG_W-FRAC_W-1:0] zq, zt;
  logic signed [8:0] ang;
  logic [8:0] own_le, own_re, ops_le, ops_re;
  logic own_seen, ops_seen;

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == ST_RECV);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = out_data;

  // The finished frame moves to the output register once that is free.
  assign load_go = (state == ST_LOAD) && (!out_valid || m_axis_tready);

  // Goal being worked on by the shared unit.
  assign gx = goal_sel ? fields[3] : fields[0];
  assign gy = goal_sel ? fields[4] : fields[1];
  assign gx_m1 = (gx == 8'hFF);
  assign gy_m1 = (gy == 8'hFF);
  assign re0 = {{(VEC_W-8-FRAC_W){gy[7]}}, gy, {FRAC_W{1'b0}}};
  assign im0 = {{(VEC_W-8-FRAC_W){gx[7]}}, gx, {FRAC_W{1'b0}}};

  // One CORDIC step; arithmetic shifts round toward minus infinity.
  assign re_sh = re >>> iter[TBL_W-1:0];
  assign im_sh = im >>> iter[TBL_W-1:0];
  assign atan_i = ATAN_TABLE[iter[TBL_W-1:0]];

  // Whole degrees, truncated toward zero, clamped.
  assign zq = z[ANG_W-1:FRAC_W];
  always_comb begin
    zt = zq;
    if (z[ANG_W-1] && (z[FRAC_W-1:0] != '0)) begin
      zt = zq + 1'b1;
    end
    if (zt > 10'(DEG_MAX)) begin
      ang = DEG_MAX;
    end else if (zt < 10'(DEG_MIN)) begin
      ang = DEG_MIN;
    end else begin
      ang = zt[8:0];
    end
  end

  // Goal ends: x minus and plus half the width.
  assign own_le = {fields[0][7], fields[0]} - {2'b00, fields[2][7:1]};
  assign own_re = {fields[0][7], fields[0]} + {2'b00, fields[2][7:1]};
  assign ops_le = {fields[3][7], fields[3]} - {2'b00, fields[5][7:1]};
  assign ops_re = {fields[3][7], fields[3]} + {2'b00, fields[5][7:1]};

  assign own_seen = vis_mode ? (fields[2] >= own_thr)
                             : !(fields[0] == 8'hFF && fields[1] == 8'hFF);
  assign ops_seen = vis_mode ? (fields[5] >= ops_thr)
                             : !(fields[3] == 8'hFF && fields[4] == 8'hFF);

  always_ff @(posedge clk) begin
    if (rst) begin
      vis_mode <= 1'b0;
      own_thr <= '0;
      ops_thr <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_VIS_MODE: vis_mode <= cfg_wdata[0];
        REG_OWN_THR:  own_thr <= cfg_wdata;
        REG_OPS_THR:  ops_thr <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Frame bytes: written by position, read at fixed places.
  always_ff @(posedge clk) begin
    if (in_acc && pos >= 3'd1 && pos <= 3'd6) begin
      fields[pos - 3'd1] <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RECV;
      pos <= '0;
      goal_sel <= 1'b0;
      iter <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_go) begin
        out_valid <= 1'b1;
      end else if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_RECV: begin
          if (in_acc) begin
            if (pos == 3'd0 || pos == 3'd7) begin
              pos <= (s_axis_tdata == HEADER_BYTE) ? 3'd1 : 3'd0;
            end else if (pos < 3'd6) begin
              pos <= pos + 3'd1;
            end else begin
              pos <= '0;
              goal_sel <= 1'b0;
              state <= ST_PREP;
            end
          end
        end
        ST_PREP: begin
          iter <= '0;
          // A special case settles the bearing without any iteration.
          if ((gx_m1 && gy_m1) || gy == 8'h00) begin
            if (goal_sel) begin
              state <= ST_LOAD;
            end else begin
              goal_sel <= 1'b1;
            end
          end else begin
            state <= ST_ITER;
          end
        end
        ST_ITER: begin
          if (im == '0 || iter == ITER_W'(NITER - 1)) begin
            state <= ST_FIN;
          end
          iter <= iter + 1'b1;
        end
        ST_FIN: begin
          if (goal_sel) begin
            state <= ST_LOAD;
          end else begin
            goal_sel <= 1'b1;
            state <= ST_PREP;
          end
        end
        ST_LOAD: begin
          if (load_go) begin
            state <= ST_RECV;
          end
        end
        default: state <= ST_RECV;
      endcase
    end
  end

  // Shared CORDIC datapath and bearing registers.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_PREP: begin
        if (gy[7]) begin
          re <= -re0;
          im <= -im0;
          z <= gx[7] ? BASE_NEG : BASE_POS;
        end else begin
          re <= re0;
          im <= im0;
          z <= '0;
        end
        if (gx_m1 && gy_m1) begin
          if (goal_sel) ops_brg <= NOT_LOCATED;
          else own_brg <= NOT_LOCATED;
        end else if (gy == 8'h00) begin
          if (goal_sel) begin
            ops_brg <= (gx == 8'h00) ? 9'sd0 : (gx[7] ? DEG_LEFT : DEG_RIGHT);
          end else begin
            own_brg <= (gx == 8'h00) ? 9'sd0 : (gx[7] ? DEG_LEFT : DEG_RIGHT);
          end
        end
      end
      ST_ITER: begin
        if (im != '0) begin
          if (!im[VEC_W-1]) begin
            re <= re + im_sh;
            im <= im - re_sh;
            z <= z + ANG_W'(atan_i);
          end else begin
            re <= re - im_sh;
            im <= im + re_sh;
            z <= z - ANG_W'(atan_i);
          end
        end
      end
      ST_FIN: begin
        if (goal_sel) ops_brg <= ang;
        else own_brg <= ang;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_LOAD && (!out_valid || m_axis_tready)) begin
      out_data <= {ops_seen, own_seen, ops_brg, own_brg, ops_re, ops_le, own_re, own_le,
                   fields[4], fields[3], fields[1], fields[0]};
    end
  end

`include "goal_frame_decoder_with_bearing_assert.svh"

  `GFD_ASSERT_NEXT(a_last_byte_starts, in_acc && pos == 3'd6, state == ST_PREP)
  `GFD_ASSERT_NOW(a_iter_bound, state == ST_ITER, iter < ITER_W'(NITER))
  `GFD_ASSERT_NEXT(a_load_shows, state == ST_LOAD && (!out_valid || m_axis_tready),
                   m_axis_tvalid && state == ST_RECV)
  `GFD_ASSERT_NOW(a_bearing_range, m_axis_tvalid,
                  $signed(m_axis_tdata[76:68]) >= NOT_LOCATED &&
                  $signed(m_axis_tdata[76:68]) <= DEG_MAX &&
                  $signed(m_axis_tdata[85:77]) >= NOT_LOCATED &&
                  $signed(m_axis_tdata[85:77]) <= DEG_MAX)

endmodule

@@ tb/goal_frame_decoder_with_bearing_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for goal_frame_decoder_with_bearing: camera byte streams
// in, decoded goal frames out, each compared field by field with a local prediction.
// Depends on gfd_pkg and the decoder RTL only.
module goal_frame_decoder_with_bearing_tb;
  import gfd_pkg::*;

  localparam int ANGLE_STEPS = 12;
  localparam int SETTLE_CYCLES = 2 * (ANGLE_STEPS + 2) + 9;
  localparam int NUM_PHASES = 6;
  localparam int BYTES_PER_PHASE = 340;
  localparam logic [1:0] REG_SPARE = 2'd3;

  // atan(2^-i) in units of 2^-16 degree.
  localparam longint ARC_STEP [16] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115
  };

  // Opening requests: two stray bytes, then three frames covering the
  // not-located goal, the zero vector, both zero-y cases, the coordinate
  // and width extremes, and a header byte taken as frame data.
  localparam logic [7:0] OPENING [23] = '{
    8'h00, 8'hFF,
    HEADER_BYTE, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00,
    HEADER_BYTE, 8'h7F, 8'h00, 8'hFF, 8'h80, 8'h00, 8'h01,
    HEADER_BYTE, 8'h80, 8'h80, 8'hFE, HEADER_BYTE, 8'h7F, 8'h80
  };

  // Result layout, highest field first so that own_x sits in the lowest bits.
  typedef struct packed {
    logic ops_seen;
    logic own_seen;
    logic signed [8:0] ops_bearing;
    logic signed [8:0] own_bearing;
    logic signed [8:0] ops_right_end;
    logic signed [8:0] ops_left_end;
    logic signed [8:0] own_right_end;
    logic signed [8:0] own_left_end;
    logic signed [7:0] ops_y;
    logic signed [7:0] ops_x;
    logic signed [7:0] own_y;
    logic signed [7:0] own_x;
  } goal_frame_t;

  class goal_result_tracker;
    int pos;
    logic [7:0] field [5];
    logic vis_mode;
    logic [7:0] own_thr;
    logic [7:0] ops_thr;
    goal_frame_t pending [$];
    int errors;
    int results;

    function new();
      pos = 0;
      vis_mode = 1'b0;
      own_thr = 8'h00;
      ops_thr = 8'h00;
      errors = 0;
      results = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        REG_VIS_MODE: vis_mode = val[0];
        REG_OWN_THR: own_thr = val;
        REG_OPS_THR: ops_thr = val;
        default: ;
      endcase
    endfunction

    // Fixed-point CORDIC vectoring on (y, x), truncated to whole degrees.
    function int goal_bearing(int x, int y);
      longint re, im, z, nre, nim, deg;
      int n;
      if (x == -1 && y == -1) return int'(NOT_LOCATED);
      if (x == 0 && y == 0) return 0;
      if (y == 0) return (x > 0) ? 90 : -90;
      re = longint'(y) * 65536;
      im = longint'(x) * 65536;
      z = 0;
      if (re < 0) begin
        z = (x >= 0) ? 180 * 65536 : -180 * 65536;
        re = -re;
        im = -im;
      end
      n = (ANGLE_STEPS > 16) ? 16 : ANGLE_STEPS;
      for (int i = 0; i < n && im != 0; i++) begin
        if (im > 0) begin
          nre = re + (im >>> i);
          nim = im - (re >>> i);
          z += ARC_STEP[i];
        end else begin
          nre = re - (im >>> i);
          nim = im + (re >>> i);
          z -= ARC_STEP[i];
        end
        re = nre;
        im = nim;
      end
      deg = z / 65536;
      if (deg > 180) deg = 180;
      if (deg < -180) deg = -180;
      return int'(deg);
    endfunction

    function bit goal_seen(int x, int y, int w, int thr);
      if (vis_mode) return w >= thr;
      return !(x == -1 && y == -1);
    endfunction

    function void take_byte(logic [7:0] b);
      goal_frame_t f;
      int ox, oy, ow, px, py, pw;
      if (pos == 0 || pos > 6) begin
        pos = (b == HEADER_BYTE) ? 1 : 0;
        return;
      end
      if (pos < 6) begin
        field[pos - 1] = b;
        pos++;
        return;
      end
      pos = 0;
      ox = int'($signed(field[0]));
      oy = int'($signed(field[1]));
      ow = int'(field[2]);
      px = int'($signed(field[3]));
      py = int'($signed(field[4]));
      pw = int'(b);
      f.own_x = 8'(ox);
      f.own_y = 8'(oy);
      f.ops_x = 8'(px);
      f.ops_y = 8'(py);
      f.own_left_end = 9'(ox - ow / 2);
      f.own_right_end = 9'(ox + ow / 2);
      f.ops_left_end = 9'(px - pw / 2);
      f.ops_right_end = 9'(px + pw / 2);
      f.own_bearing = 9'(goal_bearing(ox, oy));
      f.ops_bearing = 9'(goal_bearing(px, py));
      f.own_seen = goal_seen(ox, oy, ow, int'(own_thr));
      f.ops_seen = goal_seen(px, py, pw, int'(ops_thr));
      pending.push_back(f);
    endfunction

    function void compare(string name, int want_v, int got_v);
      if (want_v != got_v) begin
        $error("%s: expected %0d, got %0d", name, want_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(logic [OUT_W-1:0] data);
      goal_frame_t got, want;
      got = data;
      results++;
      if (pending.size() == 0) begin
        $error("result with no frame outstanding: %h", data);
        errors++;
        return;
      end
      want = pending.pop_front();
      compare("own_x", int'(want.own_x), int'(got.own_x));
      compare("own_y", int'(want.own_y), int'(got.own_y));
      compare("ops_x", int'(want.ops_x), int'(got.ops_x));
      compare("ops_y", int'(want.ops_y), int'(got.ops_y));
      compare("own_left_end", int'(want.own_left_end), int'(got.own_left_end));
      compare("own_right_end", int'(want.own_right_end), int'(got.own_right_end));
      compare("ops_left_end", int'(want.ops_left_end), int'(got.ops_left_end));
      compare("ops_right_end", int'(want.ops_right_end), int'(got.ops_right_end));
      compare("own_bearing", int'(want.own_bearing), int'(got.own_bearing));
      compare("ops_bearing", int'(want.ops_bearing), int'(got.ops_bearing));
      compare("own_seen", int'(want.own_seen), int'(got.own_seen));
      compare("ops_seen", int'(want.ops_seen), int'(got.ops_seen));
    endfunction
  endclass

  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_wdata;

  goal_result_tracker tracker;
  bit calm;
  int bytes_sent;

  goal_frame_decoder_with_bearing #(
    .ANGLE_ITERATIONS(ANGLE_STEPS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Mostly no gap or a short one, now and then a long one; none while calm.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [7:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return 8'hFF;
      1: return 8'h00;
      2: return 8'h7F;
      3: return 8'h80;
      4: return HEADER_BYTE;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void pick_goal(output logic [7:0] x, output logic [7:0] y);
    case ($urandom_range(0, 7))
      0: begin
        x = 8'hFF;
        y = 8'hFF;
      end
      1: begin
        x = 8'h00;
        y = 8'h00;
      end
      2: begin
        x = pick_coord();
        y = 8'h00;
      end
      default: begin
        x = pick_coord();
        y = pick_coord();
      end
    endcase
  endfunction

  // Widths cluster round the threshold so that both sides of it are hit.
  function automatic logic [7:0] pick_width(logic [7:0] thr);
    case ($urandom_range(0, 7))
      0: return thr;
      1: return thr - 8'd1;
      2: return 8'h00;
      3: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    do @(posedge clk); while (!s_axis_tready);
    tracker.take_byte(b);
    bytes_sent++;
  endtask

  // Wait for every outstanding frame, then for the arctangent pass to wind down.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    tracker.write_reg(idx, val);
  endtask

  task automatic program_regs(input logic [7:0] mode, input logic [7:0] own,
                              input logic [7:0] ops, input bit poke_spare);
    set_reg(REG_VIS_MODE, mode);
    set_reg(REG_OWN_THR, own);
    set_reg(REG_OPS_THR, ops);
    if (poke_spare) set_reg(REG_SPARE, 8'hAA);
    cfg_we <= 1'b0;
  endtask

  // Mostly whole frames; the rest is stray bytes and frames cut short, which
  // leave the decoder out of step until it finds a header again.
  task automatic random_phase(input int quota);
    int start, k, r;
    logic [7:0] ox, oy, px, py;
    start = bytes_sent;
    while (bytes_sent - start < quota) begin
      r = $urandom_range(0, 99);
      if (r < 78) begin
        pick_goal(ox, oy);
        pick_goal(px, py);
        send_byte(HEADER_BYTE);
        send_byte(ox);
        send_byte(oy);
        send_byte(pick_width(tracker.own_thr));
        send_byte(px);
        send_byte(py);
        send_byte(pick_width(tracker.ops_thr));
      end else if (r < 90) begin
        send_byte(8'($urandom));
      end else begin
        send_byte(HEADER_BYTE);
        k = $urandom_range(1, 5);
        repeat (k) send_byte(pick_coord());
      end
    end
  endtask

  // Result side: checks every accepted result and stalls at random.
  initial begin
    int stall;
    stall = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) tracker.check_result(m_axis_tdata);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  initial begin
    tracker = new();
    calm = 1'b0;
    bytes_sent = 0;
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= 8'h00;
    cfg_we <= 1'b0;
    cfg_index <= REG_VIS_MODE;
    cfg_wdata <= 8'h00;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (OPENING[i]) send_byte(OPENING[i]);
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        settle();
        case (ph)
          1: program_regs(8'h01, 8'h00, 8'h00, 1'b0);
          2: program_regs(8'h01, 8'hFF, 8'hFF, 1'b1);
          3: program_regs(8'h01, 8'($urandom_range(1, 254)), 8'($urandom_range(1, 254)), 1'b0);
          // Only the low bit of the mode register is kept, so this selects mode 0.
          4: program_regs(8'hFE, 8'($urandom), 8'($urandom), 1'b0);
          default: program_regs(8'h01, 8'h80, 8'h01, 1'b0);
        endcase
      end
      calm = (ph == NUM_PHASES - 1);
      random_phase(BYTES_PER_PHASE);
    end
    settle();

    $display("Sent %0d bytes under %0d register settings, both visibility modes and",
             bytes_sent, NUM_PHASES);
    $display("threshold extremes included; %0d decoded frames were checked.",
             tracker.results);
    if (tracker.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
